// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Types and constants shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;

  typedef enum logic [2:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpMul = 3'd2,
    OpDiv = 3'd3,
    OpInc = 3'd4,
    OpDec = 3'd5,
    OpEq  = 3'd6,
    OpNop = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StSat     = 2'd1,
    StDivZero = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]                 opcode;
    logic signed [WordBits-1:0] a_real;
    logic signed [WordBits-1:0] a_imag;
    logic signed [WordBits-1:0] b_real;
    logic signed [WordBits-1:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [WordBits-1:0] res_real;
    logic signed [WordBits-1:0] res_imag;
    logic                       is_equal;
    logic [1:0]                 status;
  } out_t;

  typedef struct packed {
    logic                is_div;
    logic                is_mul;
    logic                dz;
    logic                sgn_re;
    logic                sgn_im;
    logic                ovf_re;
    logic                ovf_im;
    logic                sat;
    logic                eq;
    logic [WordBits-1:0] w_re;
    logic [WordBits-1:0] w_im;
  } side_t;

endpackage

// ===== rtl/cau_div.sv =====
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, two numerators over one shared divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module cau_div #(
  parameter int unsigned RW = 80,
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [RW-1:0] num_re_i,
  input  logic [RW-1:0] num_im_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_re_o,
  output logic [QW-1:0] quot_im_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned CW = DW + QW;

  logic          valid_q    [QW];
  logic [RW-1:0] rem_re_q   [QW];
  logic [RW-1:0] rem_im_q   [QW];
  logic [QW-1:0] quot_re_q  [QW];
  logic [QW-1:0] quot_im_q  [QW];
  logic [DW-1:0] den_q      [QW];
  logic [SW-1:0] side_q     [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - k;

    logic          v_in;
    logic [RW-1:0] re_in, im_in;
    logic [QW-1:0] qre_in, qim_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [CW-1:0] trial;
    logic          ge_re, ge_im;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign re_in  = num_re_i;
      assign im_in  = num_im_i;
      assign qre_in = '0;
      assign qim_in = '0;
      assign d_in   = den_i;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign re_in  = rem_re_q[k-1];
      assign im_in  = rem_im_q[k-1];
      assign qre_in = quot_re_q[k-1];
      assign qim_in = quot_im_q[k-1];
      assign d_in   = den_q[k-1];
      assign s_in   = side_q[k-1];
    end

    assign trial = CW'(d_in) << Bit;
    assign ge_re = CW'(re_in) >= trial;
    assign ge_im = CW'(im_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_re_q[k]  <= ge_re ? RW'(CW'(re_in) - trial) : re_in;
        rem_im_q[k]  <= ge_im ? RW'(CW'(im_in) - trial) : im_in;
        quot_re_q[k] <= qre_in | (QW'(ge_re) << Bit);
        quot_im_q[k] <= qim_in | (QW'(ge_im) << Bit);
        den_q[k]     <= d_in;
        side_q[k]    <= s_in;
      end
    end
  end

  assign valid_o   = valid_q[QW-1];
  assign quot_re_o = quot_re_q[QW-1];
  assign quot_im_o = quot_im_q[QW-1];
  assign side_o    = side_q[QW-1];

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, sub, mul, div, increment, decrement and compare
// on signed Q16.16 parts, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries the opcode and
//   operands a and b. Output channel out_valid_o / out_stall_i / out_data_o
//   carries one result per input transfer, in order.
//   Every result passes three stages of multiply, sum and magnitude prep,
//   one stage per quotient bit in the restoring divider, and the output
//   register. All opcodes take the same path.
//   Throughput is one transfer per cycle while the receiver takes results.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall_o rises in the same cycle; bubbles advance freely otherwise.
//   Reset clears all valid bits; no result is presented until a transfer.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cau_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cau_pkg::out_t  out_data_o
);

  localparam int unsigned W  = cau_pkg::WordBits;
  localparam int unsigned F  = cau_pkg::FracBits;
  localparam int unsigned RW = 2 * W + F;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned CW = 3 * W;
  localparam int unsigned SW = $bits(cau_pkg::side_t);
  localparam logic [W-1:0] Half = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_lin(logic signed [W:0] x);
    if (x[W] != x[W-1]) begin
      return x[W] ? {1'b1, Half} : {1'b1, ~Half};
    end
    return {1'b0, x[W-1:0]};
  endfunction

  function automatic logic [W:0] clamp_word(logic sgn, logic ovf, logic [W-1:0] q);
    if (!ovf && q == '0) begin
      return '0;
    end
    if (sgn) begin
      if (ovf || q > Half) return {1'b1, Half};
      return {1'b0, W'(-q)};
    end
    if (ovf || q > ~Half) return {1'b1, ~Half};
    return {1'b0, q};
  endfunction

  logic en;
  logic out_valid_q;
  cau_pkg::out_t out_q, out_d;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: products and linear ops
  logic                    s1_valid_q;
  logic signed [2*W-1:0]   s1_prr_q, s1_pii_q, s1_pir_q, s1_pri_q, s1_pbb_q, s1_pbi_q;
  cau_pkg::side_t          s1_side_q, s1_side_d;
  logic signed [W:0]       ar, ai, br, bi, one_x, lin_re, lin_im;
  logic [W:0]              lr, li;

  always_comb begin
    ar     = {in_data_i.a_real[W-1], in_data_i.a_real};
    ai     = {in_data_i.a_imag[W-1], in_data_i.a_imag};
    br     = {in_data_i.b_real[W-1], in_data_i.b_real};
    bi     = {in_data_i.b_imag[W-1], in_data_i.b_imag};
    one_x  = (W+1)'(1) << F;
    lin_re = '0;
    lin_im = '0;
    s1_side_d = '0;
    unique case (cau_pkg::op_e'(in_data_i.opcode))
      cau_pkg::OpAdd: begin
        lin_re = ar + br;
        lin_im = ai + bi;
      end
      cau_pkg::OpSub: begin
        lin_re = ar - br;
        lin_im = ai - bi;
      end
      cau_pkg::OpInc: begin
        lin_re = ar + one_x;
        lin_im = ai + one_x;
      end
      cau_pkg::OpDec: begin
        lin_re = ar - one_x;
        lin_im = ai - one_x;
      end
      cau_pkg::OpMul: s1_side_d.is_mul = 1'b1;
      cau_pkg::OpDiv: begin
        s1_side_d.is_div = 1'b1;
        s1_side_d.dz     = (in_data_i.b_real == '0) && (in_data_i.b_imag == '0);
      end
      cau_pkg::OpEq: begin
        s1_side_d.eq = (in_data_i.a_real == in_data_i.b_real) &&
                       (in_data_i.a_imag == in_data_i.b_imag);
      end
      default: ;
    endcase
    lr = sat_lin(lin_re);
    li = sat_lin(lin_im);
    s1_side_d.w_re = lr[W-1:0];
    s1_side_d.w_im = li[W-1:0];
    s1_side_d.sat  = lr[W] | li[W];
  end

  // Stage 2: sums of products
  logic                    s2_valid_q;
  logic signed [2*W:0]     s2_x_re_q, s2_x_im_q;
  logic [DW-1:0]           s2_den_q;
  cau_pkg::side_t          s2_side_q;
  logic signed [2*W:0]     e_rr, e_ii, e_ir, e_ri;

  assign e_rr = {s1_prr_q[2*W-1], s1_prr_q};
  assign e_ii = {s1_pii_q[2*W-1], s1_pii_q};
  assign e_ir = {s1_pir_q[2*W-1], s1_pir_q};
  assign e_ri = {s1_pri_q[2*W-1], s1_pri_q};

  // Stage 3: magnitudes, product truncation, quotient range check
  logic                    s3_valid_q;
  logic [RW-1:0]           s3_num_re_q, s3_num_im_q;
  logic [DW-1:0]           s3_den_q;
  cau_pkg::side_t          s3_side_q, s3_side_d;
  logic [2*W:0]            mag_re, mag_im, mm_re, mm_im;
  logic [RW-1:0]           num_re, num_im;
  logic [W:0]              c_re, c_im;
  logic [CW-1:0]           den_top;

  always_comb begin
    mag_re  = s2_x_re_q[2*W] ? (2*W+1)'(-s2_x_re_q) : (2*W+1)'(s2_x_re_q);
    mag_im  = s2_x_im_q[2*W] ? (2*W+1)'(-s2_x_im_q) : (2*W+1)'(s2_x_im_q);
    mm_re   = mag_re >> F;
    mm_im   = mag_im >> F;
    c_re    = clamp_word(s2_x_re_q[2*W], |mm_re[2*W:W], mm_re[W-1:0]);
    c_im    = clamp_word(s2_x_im_q[2*W], |mm_im[2*W:W], mm_im[W-1:0]);
    num_re  = RW'(mag_re[2*W-1:0]) << F;
    num_im  = RW'(mag_im[2*W-1:0]) << F;
    den_top = CW'(s2_den_q) << W;
    s3_side_d        = s2_side_q;
    s3_side_d.sgn_re = s2_x_re_q[2*W];
    s3_side_d.sgn_im = s2_x_im_q[2*W];
    s3_side_d.ovf_re = CW'(num_re) >= den_top;
    s3_side_d.ovf_im = CW'(num_im) >= den_top;
    if (s2_side_q.is_mul) begin
      s3_side_d.w_re = c_re[W-1:0];
      s3_side_d.w_im = c_im[W-1:0];
      s3_side_d.sat  = c_re[W] | c_im[W];
    end
  end

  logic           div_valid;
  logic [W-1:0]   q_re, q_im;
  logic [SW-1:0]  div_side_raw;
  cau_pkg::side_t div_side;
  logic [W:0]     d_re, d_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prr_q  <= in_data_i.a_real * in_data_i.b_real;
      s1_pii_q  <= in_data_i.a_imag * in_data_i.b_imag;
      s1_pir_q  <= in_data_i.a_imag * in_data_i.b_real;
      s1_pri_q  <= in_data_i.a_real * in_data_i.b_imag;
      s1_pbb_q  <= in_data_i.b_real * in_data_i.b_real;
      s1_pbi_q  <= in_data_i.b_imag * in_data_i.b_imag;
      s1_side_q <= s1_side_d;

      s2_x_re_q <= s1_side_q.is_div ? e_rr + e_ii : e_rr - e_ii;
      s2_x_im_q <= s1_side_q.is_div ? e_ir - e_ri : e_ir + e_ri;
      s2_den_q  <= DW'($unsigned(s1_pbb_q)) + DW'($unsigned(s1_pbi_q));
      s2_side_q <= s1_side_q;

      s3_num_re_q <= num_re;
      s3_num_im_q <= num_im;
      s3_den_q    <= s2_den_q;
      s3_side_q   <= s3_side_d;

      out_q <= out_d;
    end
  end

  // Divider stages
  cau_div #(
    .RW (RW),
    .DW (DW),
    .QW (W),
    .SW (SW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s3_valid_q),
    .num_re_i  (s3_num_re_q),
    .num_im_i  (s3_num_im_q),
    .den_i     (s3_den_q),
    .side_i    (s3_side_q),
    .valid_o   (div_valid),
    .quot_re_o (q_re),
    .quot_im_o (q_im),
    .side_o    (div_side_raw)
  );

  assign div_side = cau_pkg::side_t'(div_side_raw);

  always_comb begin
    d_re  = clamp_word(div_side.sgn_re, div_side.ovf_re, q_re);
    d_im  = clamp_word(div_side.sgn_im, div_side.ovf_im, q_im);
    out_d = '0;
    out_d.is_equal = div_side.eq;
    if (div_side.is_div) begin
      if (div_side.dz) begin
        out_d.status = cau_pkg::StDivZero;
      end else begin
        out_d.res_real = d_re[W-1:0];
        out_d.res_imag = d_im[W-1:0];
        out_d.status   = (d_re[W] | d_im[W]) ? cau_pkg::StSat : cau_pkg::StOk;
      end
    end else begin
      out_d.res_real = div_side.w_re;
      out_d.res_imag = div_side.w_im;
      out_d.status   = div_side.sat ? cau_pkg::StSat : cau_pkg::StOk;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == cau_pkg::StDivZero |->
      out_data_o.res_real == '0 && out_data_o.res_imag == '0 && !out_data_o.is_equal)
    else $error("divide by zero result not cleared");

  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_equal |->
      out_data_o.status == cau_pkg::StOk && out_data_o.res_real == '0 &&
      out_data_o.res_imag == '0)
    else $error("compare result carries arithmetic data");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(div_valid) && $stable(s3_valid_q))
    else $error("pipeline advanced during output stall");

endmodule
